### sv/htse_pkg.sv
// Shared constants, types and helper functions of the HTML tag stripper.
package htse_pkg;

   localparam int ENT_NUM     = 6;
   localparam int ENT_MAX_LEN = 6;
   localparam int BUF_DEPTH   = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [7:0] byte_type;

   localparam byte_type CH_LT    = 8'h3C;
   localparam byte_type CH_GT    = 8'h3E;
   localparam byte_type CH_AMP   = 8'h26;
   localparam byte_type CH_SLASH = 8'h2F;
   localparam byte_type CH_SPACE = 8'h20;

   localparam byte_type ENT_TEXT [ENT_NUM][ENT_MAX_LEN] = '{
      '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
      '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
      '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
      '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
      '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00},
      '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}
   };
   localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd5, 3'd6};
   localparam byte_type ENT_VAL [ENT_NUM] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20};

   localparam byte_type SCRIPT_NAME [6] = '{8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74};
   localparam byte_type STYLE_NAME [5]  = '{8'h73, 8'h74, 8'h79, 8'h6C, 8'h65};

   // One queued item: a prefix of the old entity bytes, then at most one more byte.
   typedef struct packed {
      byte_type [BUF_DEPTH-1:0] ent_bytes;
      logic [2:0]               flush_n;
      logic                     has_extra;
      byte_type                 extra;
      logic                     last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic byte_type to_lower(input byte_type b);
      return (b >= 8'h41 && b <= 8'h5A) ? byte_type'(b + 8'd32) : b;
   endfunction

endpackage

### sv/htse_if.sv
// Handshake interfaces of the request and response channels.
interface htse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface htse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_has_byte;
   logic       out_run_last;
   logic       out_text_end;
   modport source (output valid, output out_byte, output out_has_byte,
                   output out_run_last, output out_text_end, input ready);
   modport sink (input valid, input out_byte, input out_has_byte,
                 input out_run_last, input out_text_end, output ready);
endinterface

### sv/htse_front.sv
// Front end: tag, script and entity state update, one job per accepted item.
module htse_front (
   input  logic                 clock,
   input  logic                 reset,
   htse_req_if.sink             req_chan,
   input  htse_pkg::q_stat_type q_stat,
   output logic                 push,
   output htse_pkg::job_type    job
);

   logic                open_ff, open_in;
   logic                script_ff, script_in;
   logic [3:0]          off_ff, off_in;
   logic [1:0]          flags_ff, flags_in;
   logic [2:0]          cnt_ff, cnt_in;
   htse_pkg::byte_type  ent_ff [htse_pkg::BUF_DEPTH];

   htse_pkg::byte_type  b;
   logic                last;
   logic                hit;
   logic [2:0]          hit_e;
   logic                pre_ok;
   logic                fresh;
   logic [3:0]          off_n;
   logic [2:0]          off_idx;
   logic                wr_en;
   logic [2:0]          wr_idx;
   htse_pkg::byte_type  wr_data;

   assign b              = req_chan.in_byte;
   assign last           = req_chan.in_last;
   assign req_chan.ready = !q_stat.full;
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      hit    = 1'b0;
      hit_e  = '0;
      pre_ok = 1'b1;
      for (int e = 0; e < htse_pkg::ENT_NUM; e++) begin
         pre_ok = 1'b1;
         for (int k = 0; k < htse_pkg::BUF_DEPTH; k++) begin
            if (k < int'(cnt_ff) && ent_ff[k] != htse_pkg::ENT_TEXT[e][k]) begin
               pre_ok = 1'b0;
            end
         end
         if (!hit && pre_ok && htse_pkg::ENT_LEN[e] > cnt_ff
             && htse_pkg::ENT_TEXT[e][cnt_ff] == b) begin
            hit   = 1'b1;
            hit_e = 3'(e);
         end
      end
   end

   assign off_n   = (off_ff == 4'd15) ? off_ff : off_ff + 4'd1;
   assign off_idx = 3'(off_n - 4'd1);

   always_comb begin
      open_in   = open_ff;
      script_in = script_ff;
      off_in    = off_ff;
      flags_in  = flags_ff;
      cnt_in    = cnt_ff;
      wr_en     = 1'b0;
      wr_idx    = '0;
      wr_data   = b;
      fresh     = 1'b0;
      for (int k = 0; k < htse_pkg::BUF_DEPTH; k++) begin
         job.ent_bytes[k] = ent_ff[k];
      end
      job.flush_n   = '0;
      job.has_extra = 1'b0;
      job.extra     = '0;
      job.last      = last;

      if (cnt_ff != 3'd0) begin
         if (hit) begin
            if (cnt_ff + 3'd1 == htse_pkg::ENT_LEN[hit_e]) begin
               cnt_in        = '0;
               job.has_extra = 1'b1;
               job.extra     = htse_pkg::ENT_VAL[hit_e];
            end else begin
               wr_en  = 1'b1;
               wr_idx = cnt_ff;
               cnt_in = cnt_ff + 3'd1;
            end
         end else begin
            job.flush_n = cnt_ff;
            cnt_in      = '0;
            fresh       = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end

      if (fresh) begin
         if (!open_ff) begin
            if (b == htse_pkg::CH_LT) begin
               open_in  = 1'b1;
               off_in   = '0;
               flags_in = 2'b11;
            end else if (script_ff) begin
               open_in = open_ff;
            end else if (b == htse_pkg::CH_AMP) begin
               wr_en   = 1'b1;
               wr_idx  = '0;
               wr_data = htse_pkg::CH_AMP;
               cnt_in  = 3'd1;
            end else begin
               job.has_extra = 1'b1;
               job.extra     = b;
            end
         end else begin
            off_in = off_n;
            if (off_n == 4'd1 && b == htse_pkg::CH_SLASH && script_ff) begin
               script_in = 1'b0;
            end
            if (flags_ff[0]) begin
               if (off_n <= 4'd6) begin
                  if (htse_pkg::to_lower(b) != htse_pkg::SCRIPT_NAME[off_idx]) begin
                     flags_in[0] = 1'b0;
                  end
               end else begin
                  script_in   = 1'b1;
                  flags_in[0] = 1'b0;
               end
            end
            if (flags_ff[1]) begin
               if (off_n <= 4'd5) begin
                  if (htse_pkg::to_lower(b) != htse_pkg::STYLE_NAME[off_idx]) begin
                     flags_in[1] = 1'b0;
                  end
               end else begin
                  script_in   = 1'b1;
                  flags_in[1] = 1'b0;
               end
            end
            if (b == htse_pkg::CH_GT) begin
               open_in       = 1'b0;
               job.has_extra = 1'b1;
               job.extra     = htse_pkg::CH_SPACE;
            end
         end
      end

      // At the end of the text a pending entity is given back literally.
      if (last) begin
         if (cnt_in != 3'd0) begin
            job.flush_n   = job.flush_n + cnt_in - 3'd1;
            job.has_extra = 1'b1;
            job.extra     = wr_data;
         end
         open_in   = 1'b0;
         script_in = 1'b0;
         off_in    = '0;
         flags_in  = '0;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         script_ff <= 1'b0;
         off_ff    <= '0;
         flags_ff  <= '0;
         cnt_ff    <= '0;
      end else if (push) begin
         open_ff   <= open_in;
         script_ff <= script_in;
         off_ff    <= off_in;
         flags_ff  <= flags_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && wr_en) begin
         ent_ff[wr_idx] <= wr_data;
      end
   end

endmodule

### sv/htse_queue.sv
// Job queue between the front end and the result sequencer.
module htse_queue #(
   parameter int DEPTH = htse_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  htse_pkg::job_type    push_job,
   input  logic                 pop,
   output htse_pkg::job_type    pop_job,
   output htse_pkg::q_stat_type q_stat
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   htse_pkg::job_type mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   assign wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   assign q_stat.full  = (cnt_ff == CntW'(DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign pop_job      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### sv/htse_back.sv
// Back end: expands one job into its result items through an output register.
module htse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  htse_pkg::q_stat_type q_stat,
   input  htse_pkg::job_type    q_job,
   output logic                 pop,
   htse_rsp_if.source           rsp_chan
);

   htse_pkg::job_type  cur_ff;
   logic               cur_valid_ff;
   logic [2:0]         pos_ff;
   logic               rsp_valid_ff;
   htse_pkg::byte_type byte_ff;
   logic               has_byte_ff;
   logic               run_last_ff;
   logic               text_end_ff;

   logic [2:0]         total;
   logic               is_final;
   logic               skip;
   logic               advance;
   logic               fin;
   htse_pkg::byte_type res_byte;

   // A job that yields no byte and does not end the text gives no result item.
   assign total    = cur_ff.flush_n + {2'b00, cur_ff.has_extra};
   assign is_final = (total == 3'd0) || (pos_ff == total - 3'd1);
   assign skip     = cur_valid_ff && (total == 3'd0) && !cur_ff.last;
   assign advance  = cur_valid_ff && !skip && (!rsp_valid_ff || rsp_chan.ready);
   assign fin      = skip || (advance && is_final);
   assign pop      = !q_stat.empty && (!cur_valid_ff || fin);
   assign res_byte = (pos_ff < cur_ff.flush_n) ? cur_ff.ent_bytes[pos_ff] :
                     (cur_ff.has_extra ? cur_ff.extra : 8'h00);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cur_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop) begin
            cur_valid_ff <= 1'b1;
            pos_ff       <= '0;
         end else if (fin) begin
            cur_valid_ff <= 1'b0;
         end else if (advance) begin
            pos_ff <= pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_job;
      end
      if (advance) begin
         byte_ff     <= res_byte;
         has_byte_ff <= (total != 3'd0);
         run_last_ff <= is_final;
         text_end_ff <= is_final && cur_ff.last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = byte_ff;
   assign rsp_chan.out_has_byte = has_byte_ff;
   assign rsp_chan.out_run_last = run_last_ff;
   assign rsp_chan.out_text_end = text_end_ff;

endmodule

### sv/html_tag_strip_entity_decode_core.sv
// Top level of the HTML tag stripper with entity decoding.
// The first result of an item passes the job queue, the current-job register and the output register.
// Throughput: one input item per cycle while each item gives at most one result and rsp_chan
// is ready. The sequencer gives one result per cycle unless stalled; a job has n <= 6 results.
// Reset: synchronous; clears tag, script and entity state, the queue and the output register.
// The entity byte store is not cleared and needs no clearing pass.
module html_tag_strip_entity_decode_core #(
   parameter int QUEUE_DEPTH = htse_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   htse_req_if.sink   req_chan,
   htse_rsp_if.source rsp_chan
);

   htse_pkg::q_stat_type q_stat;
   htse_pkg::job_type    push_job;
   htse_pkg::job_type    pop_job;
   logic                 push;
   logic                 pop;

   htse_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .job      (push_job)
   );

   htse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_stat   (q_stat)
   );

   htse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .q_job    (pop_job),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_chan.ready)
      else $error("Request taken while the job queue is full.");

   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !q_stat.empty)
      else $error("Accepted item did not reach the job queue.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.out_has_byte) |->
         (rsp_chan.out_text_end && rsp_chan.out_run_last && rsp_chan.out_byte == 8'h00))
      else $error("Empty result item that is not an end-of-text marker.");

endmodule
